// ===== sv/lscn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lscn_pkg;

  // fixed field widths
  localparam int REG_W      = 12;
  localparam int CHAN_W     = 3;
  localparam int REQ_W      = 2;
  localparam int NORM_OUT_W = 10;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_SCAN  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WHITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_BLACK = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN  = 2'd1;

  localparam logic [REG_W-1:0] MIN_SPAN_RST  = 12'd32;
  localparam logic [REG_W-1:0] THRESHOLD_RST = 12'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/lscn_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lscn_in_if #(
  parameter int ADC_BITS = 12
) ();
  import lscn_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [CHAN_W-1:0]   chan;
  logic [ADC_BITS-1:0] sample_a;
  logic [ADC_BITS-1:0] sample_b;
  logic [ADC_BITS-1:0] sample_c;
  logic [ADC_BITS-1:0] sample_d;

  modport source (
    output valid, req_type, chan, sample_a, sample_b, sample_c, sample_d,
    input  ready
  );
  modport sink (
    input  valid, req_type, chan, sample_a, sample_b, sample_c, sample_d,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/lscn_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lscn_out_if #(
  parameter int ADC_BITS = 12
) ();
  import lscn_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CHAN_W-1:0]     chan_out;
  logic [ADC_BITS-1:0]   raw_level;
  logic [NORM_OUT_W-1:0] norm_level;
  logic                  norm_valid;
  logic [COUNT_W-1:0]    active_count;

  modport source (
    output valid, chan_out, raw_level, norm_level, norm_valid, active_count,
    input  ready
  );
  modport sink (
    input  valid, chan_out, raw_level, norm_level, norm_valid, active_count,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/lscn_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lscn_cfg_if ();
  import lscn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/line_sensor_calibrated_normalizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// two-point calibrated normalizer for a multiplexed line-sensor bar
//
// in_ch: one transfer per channel conversion group (request kind, channel,
//   four kept samples). the samples are averaged into the raw level, which
//   is stored per channel and, on a white or black capture, also kept as
//   that channel's reference.
// out_ch: one result per input transfer, in order: channel, raw level,
//   normalized level (0 white .. NORM_MAX black), valid flag, active count.
// cfg_ch: register writes (0 active threshold, 1 min span), always ready;
//   write only while no item is in flight.
// timing: an item is taken only in idle. the normalized value comes out of
//   a bit-serial shift-add multiply by NORM_MAX and a bit-serial restoring
//   divide, each stepping over NW = clog2(NORM_MAX+1) bits; the next item
//   is taken only after the result of the last one is loaded into the output
//   register. items whose result is 0 or clamped skip the serial loops.
// stall: the result sits in an output register; if the receiver holds
//   ready low the finished item waits in the done state and no new item
//   is taken until the output register frees up.
// reset: synchronous, active low; clears references, stored raw levels,
//   capture marks, the registers to their defaults and the output valid.
module line_sensor_calibrated_normalizer #(
  parameter int CHANNELS = 8,
  parameter int ADC_BITS = 12,
  parameter int NORM_MAX = 1000
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lscn_in_if.sink     in_ch,
  lscn_out_if.source  out_ch,
  lscn_cfg_if.sink    cfg_ch
);
  import lscn_pkg::*;

  // width of the normalized value and of the serial product
  localparam int NW   = $clog2(NORM_MAX + 1);
  localparam int PW   = ADC_BITS + NW;
  localparam int CNTW = (NW > 1) ? $clog2(NW) : 1;
  localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMPW = (ADC_BITS > REG_W) ? ADC_BITS : REG_W;
  localparam logic [NW-1:0] NMAX = NW'(NORM_MAX);

  // configuration registers
  logic [REG_W-1:0] threshold_r;
  logic [REG_W-1:0] min_span_r;

  // per-channel state
  logic [ADC_BITS-1:0] raw_store_r [CHANNELS];
  logic [ADC_BITS-1:0] white_ref_r [CHANNELS];
  logic [ADC_BITS-1:0] black_ref_r [CHANNELS];
  logic [CHANNELS-1:0] white_seen_r;
  logic [CHANNELS-1:0] black_seen_r;

  // item context
  state_t              state_r, state_nxt;
  logic [CHAN_W-1:0]   chan_r;
  logic [ADC_BITS-1:0] raw_r;
  logic                in_range_r;
  logic                valid_r;
  logic [COUNT_W-1:0]  count_r;
  logic [ADC_BITS-1:0] dmag_r;
  logic [ADC_BITS-1:0] smag_r;
  logic [NW-1:0]       norm_r;

  // serial datapath: acc holds the product, then {remainder, quotient}
  logic [PW-1:0]   acc_r;
  logic [NW-1:0]   nsh_r;
  logic [CNTW-1:0] cnt_r;

  // output register
  logic                  out_vld_r;
  logic [CHAN_W-1:0]     out_chan_r;
  logic [ADC_BITS-1:0]   out_raw_r;
  logic [NORM_OUT_W-1:0] out_norm_r;
  logic                  out_flag_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                in_fire;
  logic                in_range;
  logic [CIW-1:0]      in_idx;
  logic [CIW-1:0]      cur_idx;
  logic [ADC_BITS+1:0] sum;
  logic [ADC_BITS-1:0] raw;
  logic                out_free;
  logic                load_out;
  logic                cnt_last;

  logic [REG_W-1:0]      span_lim;
  logic                  both_full;
  logic                  all_ok;
  logic [COUNT_W-1:0]    count_c;
  logic signed [ADC_BITS:0] d_c;
  logic signed [ADC_BITS:0] s_c;
  logic [ADC_BITS-1:0]   dmag_c;
  logic [ADC_BITS-1:0]   smag_c;
  logic                  norm_zero;
  logic                  clamp;
  logic                  go_mul;

  logic [PW-1:0]       acc_mul_nxt;
  logic [ADC_BITS:0]   div_t;
  logic [ADC_BITS:0]   div_diff;
  logic                div_ge;
  logic [ADC_BITS-1:0] div_rem;
  logic [NW:0]         div_low;
  logic [PW-1:0]       acc_div_nxt;

  function automatic logic [ADC_BITS-1:0] mag(input logic signed [ADC_BITS:0] v);
    logic signed [ADC_BITS:0] a;
    a = (v < 0) ? -v : v;
    return a[ADC_BITS-1:0];
  endfunction

  function automatic logic span_ok(input logic [ADC_BITS-1:0] m,
                                   input logic [REG_W-1:0] lim);
    return CMPW'(m) >= CMPW'(lim);
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_range = {1'b0, in_ch.chan} < (CHAN_W + 1)'(CHANNELS);
  assign in_idx   = in_ch.chan[CIW-1:0];
  assign cur_idx  = chan_r[CIW-1:0];
  assign sum      = (ADC_BITS + 2)'(in_ch.sample_a) + (ADC_BITS + 2)'(in_ch.sample_b)
                  + (ADC_BITS + 2)'(in_ch.sample_c) + (ADC_BITS + 2)'(in_ch.sample_d);
  assign raw      = sum[ADC_BITS+1:2];
  assign out_free = !out_vld_r || out_ch.ready;
  assign cnt_last = (cnt_r == CNTW'(NW - 1));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_vld_r;
  assign out_ch.chan_out     = out_chan_r;
  assign out_ch.raw_level    = out_raw_r;
  assign out_ch.norm_level   = out_norm_r;
  assign out_ch.norm_valid   = out_flag_r;
  assign out_ch.active_count = out_count_r;

  // evaluation over the updated state: flags, count, operand magnitudes
  always_comb begin
    span_lim  = (min_span_r == '0) ? REG_W'(1) : min_span_r;
    both_full = (&white_seen_r) && (&black_seen_r);
    all_ok    = 1'b1;
    count_c   = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (!span_ok(mag((ADC_BITS + 1)'(black_ref_r[i]) - (ADC_BITS + 1)'(white_ref_r[i])),
                   span_lim)) begin
        all_ok = 1'b0;
      end
      if (CMPW'(raw_store_r[i]) >= CMPW'(threshold_r)) begin
        count_c = count_c + COUNT_W'(1);
      end
    end
    d_c    = (ADC_BITS + 1)'(raw_store_r[cur_idx]) - (ADC_BITS + 1)'(white_ref_r[cur_idx]);
    s_c    = (ADC_BITS + 1)'(black_ref_r[cur_idx]) - (ADC_BITS + 1)'(white_ref_r[cur_idx]);
    dmag_c = mag(d_c);
    smag_c = mag(s_c);
    // negative quotient truncates up to zero, then clamps at zero
    norm_zero = !(both_full && in_range_r && span_ok(smag_c, span_lim))
             || ((d_c < 0) != (s_c < 0) && d_c != '0);
    // |d| >= |s| means the quotient reaches NORM_MAX
    clamp  = dmag_c >= smag_c;
    go_mul = !norm_zero && !clamp;
  end

  // serial multiply step (msb first) and restoring divide step
  always_comb begin
    acc_mul_nxt = {acc_r[PW-2:0], 1'b0} + (nsh_r[NW-1] ? PW'(dmag_r) : PW'(0));
    div_t       = {acc_r[PW-1:NW], acc_r[NW-1]};
    div_diff    = div_t - {1'b0, smag_r};
    div_ge      = div_t >= {1'b0, smag_r};
    div_rem     = div_ge ? div_diff[ADC_BITS-1:0] : div_t[ADC_BITS-1:0];
    div_low     = {acc_r[NW-1:0], div_ge};
    acc_div_nxt = {div_rem, div_low[NW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = go_mul ? S_MUL : S_DONE;
      end
      S_MUL: begin
        if (cnt_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration and per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      min_span_r   <= MIN_SPAN_RST;
      white_seen_r <= '0;
      black_seen_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        raw_store_r[i] <= '0;
        white_ref_r[i] <= '0;
        black_ref_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_THRESHOLD: threshold_r <= cfg_ch.data;
          CFG_MIN_SPAN:  min_span_r  <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_fire && in_range) begin
        raw_store_r[in_idx] <= raw;
        case (in_ch.req_type)
          REQ_WHITE: begin
            white_ref_r[in_idx]  <= raw;
            white_seen_r[in_idx] <= 1'b1;
          end
          REQ_BLACK: begin
            black_ref_r[in_idx]  <= raw;
            black_seen_r[in_idx] <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            chan_r     <= in_ch.chan;
            raw_r      <= raw;
            in_range_r <= in_range;
          end
          cnt_r <= '0;
        end
        S_EVAL: begin
          valid_r <= both_full && all_ok;
          count_r <= count_c;
          dmag_r  <= dmag_c;
          smag_r  <= smag_c;
          norm_r  <= (!norm_zero && clamp) ? NMAX : '0;
          acc_r   <= '0;
          nsh_r   <= NMAX;
          cnt_r   <= '0;
        end
        S_MUL: begin
          acc_r <= acc_mul_nxt;
          nsh_r <= nsh_r << 1;
          cnt_r <= cnt_last ? '0 : cnt_r + CNTW'(1);
        end
        S_DIV: begin
          acc_r <= acc_div_nxt;
          cnt_r <= cnt_last ? '0 : cnt_r + CNTW'(1);
          if (cnt_last) norm_r <= acc_div_nxt[NW-1:0];
        end
        default: ;
      endcase
    end
  end

  // output register, freed by a transfer on out_ch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_chan_r  <= chan_r;
      out_raw_r   <= raw_r;
      out_norm_r  <= NORM_OUT_W'(norm_r);
      out_flag_r  <= valid_r;
      out_count_r <= count_r;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lscn_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lscn_checker #(
  parameter int CHANNELS = 8
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [lscn_pkg::NORM_OUT_W-1:0] norm_level,
  input wire logic [lscn_pkg::COUNT_W-1:0]    active_count
);
  import lscn_pkg::*;

  // one item at a time: no transfer in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> active_count <= COUNT_W'(CHANNELS))
    else $error("active count above channel count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(norm_level))
    else $error("stalled result dropped or changed");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind line_sensor_calibrated_normalizer lscn_checker #(.CHANNELS(CHANNELS)) u_lscn_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .norm_level   (out_ch.norm_level),
  .active_count (out_ch.active_count)
);
`default_nettype wire

// ===== tb/sv/line_sensor_calibrated_normalizer_test.sv =====
`timescale 1ns / 1ps
module line_sensor_calibrated_normalizer_test;
  import lscn_pkg::*;

  localparam int CHANNELS    = 8;
  localparam int ADC_BITS    = 12;
  localparam int NORM_MAX    = 1000;
  localparam int ADC_TOP     = (1 << ADC_BITS) - 1;
  localparam int PHASE_ITEMS = 265;
  localparam int TAIL_CYCLES = 60;
  localparam int PRINT_LIMIT = 40;

  // request kind 3 is not defined by the block and must act as a plain scan
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // one result transfer as the block should present it
  typedef struct packed {
    logic [CHAN_W-1:0]     chan;
    logic [ADC_BITS-1:0]   raw;
    logic [NORM_OUT_W-1:0] norm;
    logic                  valid;
    logic [COUNT_W-1:0]    count;
  } level_result_t;

  logic clk;
  logic rst_n;

  lscn_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
  lscn_out_if #(.ADC_BITS(ADC_BITS)) out_ch ();
  lscn_cfg_if cfg_ch ();

  line_sensor_calibrated_normalizer #(
    .CHANNELS(CHANNELS),
    .ADC_BITS(ADC_BITS),
    .NORM_MAX(NORM_MAX)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the block's per-channel state and registers
  logic [ADC_BITS-1:0] raw_shadow   [CHANNELS];
  logic [ADC_BITS-1:0] white_shadow [CHANNELS];
  logic [ADC_BITS-1:0] black_shadow [CHANNELS];
  logic [CHANNELS-1:0] white_seen;
  logic [CHANNELS-1:0] black_seen;
  logic [REG_W-1:0]    threshold_shadow;
  logic [REG_W-1:0]    min_span_shadow;

  // results still owed by the block, oldest first
  level_result_t pending_levels[$];

  int in_idle_pct    = 0;
  int out_stall_pct  = 0;
  int mismatch_count = 0;
  int items_sent     = 0;

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // a zero span register behaves as one, so a flat channel never divides
  function automatic bit span_usable(input int span);
    int lim;
    lim = (min_span_shadow == '0) ? 1 : int'(min_span_shadow);
    return (span >= lim) || (span <= -lim);
  endfunction

  function automatic int span_of(input int ch);
    return int'(black_shadow[ch]) - int'(white_shadow[ch]);
  endfunction

  // updates the shadow state for one accepted item and returns its result
  function automatic level_result_t predict_level(
    input logic [REQ_W-1:0]    req,
    input logic [CHAN_W-1:0]   ch,
    input logic [ADC_BITS-1:0] a,
    input logic [ADC_BITS-1:0] b,
    input logic [ADC_BITS-1:0] c,
    input logic [ADC_BITS-1:0] d
  );
    level_result_t r;
    int            total;
    int            span;
    int            q;
    total   = int'(a) + int'(b) + int'(c) + int'(d);
    r.chan  = ch;
    r.raw   = ADC_BITS'(total / 4);
    r.norm  = '0;
    r.valid = 1'b0;
    r.count = '0;

    // every 3-bit channel index lies inside the bar, so the store always happens
    raw_shadow[ch] = r.raw;
    if (req == REQ_WHITE) begin
      white_shadow[ch] = r.raw;
      white_seen[ch]   = 1'b1;
    end else if (req == REQ_BLACK) begin
      black_shadow[ch] = r.raw;
      black_seen[ch]   = 1'b1;
    end

    // normalization only once both reference sets are complete
    if (&white_seen && &black_seen) begin
      r.valid = 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        if (!span_usable(span_of(i))) r.valid = 1'b0;
      end
      span = span_of(ch);
      if (span_usable(span)) begin
        // signed division truncates toward zero, then clamp to the output range
        q = ((int'(raw_shadow[ch]) - int'(white_shadow[ch])) * NORM_MAX) / span;
        if (q < 0) q = 0;
        if (q > NORM_MAX) q = NORM_MAX;
        r.norm = NORM_OUT_W'(q);
      end
    end

    // active count uses the stored levels after this item's store
    for (int i = 0; i < CHANNELS; i++) begin
      if (raw_shadow[i] >= threshold_shadow) r.count = r.count + 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // receiver side: random backpressure on the result channel
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // every result transfer is compared against the oldest prediction
  always @(posedge clk) begin
    level_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result chan %0d raw %0d",
                                  out_ch.chan_out, out_ch.raw_level));
      end else begin
        want = pending_levels.pop_front();
        if (out_ch.chan_out !== want.chan)
          report_mismatch($sformatf("chan_out got %0d want %0d",
                                    out_ch.chan_out, want.chan));
        if (out_ch.raw_level !== want.raw)
          report_mismatch($sformatf("chan %0d raw_level got %0d want %0d",
                                    want.chan, out_ch.raw_level, want.raw));
        if (out_ch.norm_level !== want.norm)
          report_mismatch($sformatf("chan %0d norm_level got %0d want %0d",
                                    want.chan, out_ch.norm_level, want.norm));
        if (out_ch.norm_valid !== want.valid)
          report_mismatch($sformatf("chan %0d norm_valid got %0d want %0d",
                                    want.chan, out_ch.norm_valid, want.valid));
        if (out_ch.active_count !== want.count)
          report_mismatch($sformatf("chan %0d active_count got %0d want %0d",
                                    want.chan, out_ch.active_count, want.count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // one input transfer; valid stays high into the next item unless an idle
  // cycle is drawn, so back-to-back items never lower and raise it in one step
  task automatic send_item(
    input logic [REQ_W-1:0]    req,
    input logic [CHAN_W-1:0]   ch,
    input logic [ADC_BITS-1:0] a,
    input logic [ADC_BITS-1:0] b,
    input logic [ADC_BITS-1:0] c,
    input logic [ADC_BITS-1:0] d
  );
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.chan     <= ch;
    in_ch.sample_a <= a;
    in_ch.sample_b <= b;
    in_ch.sample_c <= c;
    in_ch.sample_d <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_levels.push_back(predict_level(req, ch, a, b, c, d));
    items_sent++;
  endtask

  // sample value scattered around a level, kept inside the converter range
  function automatic logic [ADC_BITS-1:0] near(input int level, input int spread);
    int v;
    v = level + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > ADC_TOP) v = ADC_TOP;
    return ADC_BITS'(v);
  endfunction

  task automatic send_level(
    input logic [REQ_W-1:0]  req,
    input logic [CHAN_W-1:0] ch,
    input int                level,
    input int                spread
  );
    send_item(req, ch, near(level, spread), near(level, spread),
              near(level, spread), near(level, spread));
  endtask

  // holds the input side until every owed result has been taken
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // register writes happen only with the block drained
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [REG_W-1:0]     value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_THRESHOLD) threshold_shadow = value;
    else if (idx == CFG_MIN_SPAN) min_span_shadow = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    in_idle_pct   = sender_pct;
    out_stall_pct = receiver_pct;
  endtask

  // white and black capture of one channel, in random order; a narrow
  // channel gets a span at most the current minimum
  task automatic calibrate_channel(input logic [CHAN_W-1:0] ch, input bit narrow);
    int w;
    int b;
    int mag;
    w = $urandom_range(ADC_TOP);
    if (narrow) mag = $urandom_range(int'(min_span_shadow));
    else mag = $urandom_range(3000, 100);
    // inverted sensor on about a quarter of the channels
    if ($urandom_range(3) == 0) mag = -mag;
    b = w + mag;
    if (b > ADC_TOP || b < 0) b = w - mag;
    if ($urandom_range(1) == 0) begin
      send_level(REQ_WHITE, ch, w, 2);
      send_level(REQ_BLACK, ch, b, 2);
    end else begin
      send_level(REQ_BLACK, ch, b, 2);
      send_level(REQ_WHITE, ch, w, 2);
    end
  endtask

  task automatic calibrate_all();
    int start;
    int narrow_ch;
    start     = $urandom_range(CHANNELS - 1);
    narrow_ch = ($urandom_range(3) == 0) ? int'($urandom_range(CHANNELS - 1)) : -1;
    for (int i = 0; i < CHANNELS; i++) begin
      calibrate_channel(CHAN_W'((start + i) % CHANNELS), ((start + i) % CHANNELS) == narrow_ch);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // scans and partial captures while the reference sets are incomplete:
  // extremes of the samples, the unused request kind, threshold at its top
  task automatic test_uncalibrated();
    send_item(REQ_SCAN, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_item(REQ_UNUSED, 3'd7, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_item(REQ_WHITE, 3'd3, 12'hfff, 12'd0, 12'hfff, 12'd0);
    send_item(REQ_BLACK, 3'd3, 12'd1, 12'd2, 12'd3, 12'd4);
    write_register(CFG_THRESHOLD, 12'hfff);
    send_item(REQ_SCAN, 3'd7, 12'hfff, 12'hfff, 12'hfff, 12'hffe);
  endtask

  // full white then black capture, channel 5 mounted inverted
  task automatic test_calibration();
    write_register(CFG_THRESHOLD, 12'd2000);
    for (int i = 0; i < CHANNELS; i++) begin
      send_level(REQ_WHITE, CHAN_W'(i), (i == 5) ? 3500 : 200 + 40 * i, 0);
    end
    for (int i = 0; i < CHANNELS; i++) begin
      send_level(REQ_BLACK, CHAN_W'(i), (i == 5) ? 300 : 3600 - 30 * i, 0);
    end
  endtask

  // normalized levels between the references, and clamping on both sides
  task automatic test_normalized_scans();
    send_item(REQ_SCAN, 3'd0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_item(REQ_SCAN, 3'd0, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_level(REQ_SCAN, 3'd5, 1900, 5);
    send_level(REQ_SCAN, 3'd2, 1000, 5);
  endtask

  // every span too narrow at the top minimum; then a flat channel with the
  // minimum register at zero
  task automatic test_narrow_span();
    write_register(CFG_MIN_SPAN, 12'hfff);
    send_level(REQ_SCAN, 3'd1, 2000, 5);
    write_register(CFG_MIN_SPAN, 12'd0);
    send_level(REQ_WHITE, 3'd2, 3600 - 60, 0);
    send_level(REQ_SCAN, 3'd4, 2500, 5);
  endtask

  // mostly calibrate-then-scan traffic with random content, plus broken
  // capture sequences, raw noise and occasional full drains
  task automatic test_random_traffic(input int item_total);
    int                  stop_at;
    int                  pick;
    int                  lo;
    int                  hi;
    int                  spread;
    logic [CHAN_W-1:0]   ch;
    logic [REQ_W-1:0]    req;
    stop_at = items_sent + item_total;
    calibrate_all();
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        calibrate_all();
      end else if (pick < 16) begin
        // one to three stray requests, possibly leaving a channel narrow or inverted
        repeat ($urandom_range(3, 1)) begin
          req = REQ_W'($urandom_range(3));
          send_level(req, CHAN_W'($urandom_range(CHANNELS - 1)),
                     $urandom_range(ADC_TOP), 8);
        end
      end else if (pick < 26) begin
        send_item(REQ_W'($urandom_range(3)), CHAN_W'($urandom_range(CHANNELS - 1)),
                  ADC_BITS'($urandom_range(ADC_TOP)), ADC_BITS'($urandom_range(ADC_TOP)),
                  ADC_BITS'($urandom_range(ADC_TOP)), ADC_BITS'($urandom_range(ADC_TOP)));
      end else if (pick < 28) begin
        wait_idle();
      end else begin
        repeat ($urandom_range(8, 1)) begin
          ch = CHAN_W'($urandom_range(CHANNELS - 1));
          lo = (white_shadow[ch] < black_shadow[ch]) ? int'(white_shadow[ch])
                                                     : int'(black_shadow[ch]);
          hi = (white_shadow[ch] < black_shadow[ch]) ? int'(black_shadow[ch])
                                                     : int'(white_shadow[ch]);
          lo = (lo > 200) ? lo - 200 : 0;
          hi = (hi < ADC_TOP - 200) ? hi + 200 : ADC_TOP;
          spread = ($urandom_range(9) == 0) ? 600 : 4;
          req = ($urandom_range(9) == 0) ? REQ_UNUSED : REQ_SCAN;
          send_level(req, ch, $urandom_range(hi, lo), spread);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_SCAN;
    in_ch.chan     = '0;
    in_ch.sample_a = '0;
    in_ch.sample_b = '0;
    in_ch.sample_c = '0;
    in_ch.sample_d = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_THRESHOLD;
    cfg_ch.data    = '0;

    for (int i = 0; i < CHANNELS; i++) begin
      raw_shadow[i]   = '0;
      white_shadow[i] = '0;
      black_shadow[i] = '0;
    end
    white_seen       = '0;
    black_seen       = '0;
    threshold_shadow = THRESHOLD_RST;
    min_span_shadow  = MIN_SPAN_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // light sender gaps, heavy result backpressure
    set_idling(10, 86);
    test_uncalibrated();
    test_calibration();
    test_normalized_scans();
    test_narrow_span();

    write_register(CFG_THRESHOLD, REG_W'($urandom_range(ADC_TOP)));
    write_register(CFG_MIN_SPAN, 12'd1);
    test_random_traffic(PHASE_ITEMS);

    // heavy sender gaps, light backpressure
    set_idling(86, 10);
    write_register(CFG_THRESHOLD, 12'hfff);
    write_register(CFG_MIN_SPAN, REG_W'($urandom_range(400, 1)));
    test_random_traffic(PHASE_ITEMS);

    // full rate on both sides
    set_idling(0, 0);
    write_register(CFG_THRESHOLD, REG_W'($urandom_range(3000, 1000)));
    write_register(CFG_MIN_SPAN, MIN_SPAN_RST);
    test_random_traffic(PHASE_ITEMS);

    // drain, then give any stray result time to show up
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_levels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
